FILE: rtl/core/pbwp_pkg.sv
// ----------------------------------------------------------------------------
// pbwp_pkg
// Types, codes and constants shared by the protobuf wire parser modules.
// ----------------------------------------------------------------------------
package pbwp_pkg;

  localparam int unsigned LENGTH_BITS_DEFAULT = 32;
  localparam int unsigned MAX_VARINT_BYTES    = 10;
  localparam int unsigned FIXED64_BYTES       = 8;
  localparam int unsigned FIXED32_BYTES       = 4;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_BYTES   = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_KEY     = 3'd1,
    PH_VARINT  = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DONE    = 3'd5,
    PH_ERROR   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_VARINT  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_TRUNC_VARINT  = 3'd1,
    ERR_LONG_VARINT   = 3'd2,
    ERR_FIELD_ZERO    = 3'd3,
    ERR_TRUNC_FIXED64 = 3'd4,
    ERR_TRUNC_FIXED32 = 3'd5,
    ERR_TRUNC_BYTES   = 3'd6,
    ERR_BAD_WIRE_TYPE = 3'd7
  } error_e;

  typedef struct packed {
    phase_e      phase;
    logic [63:0] acc;
    logic [3:0]  shift;
    logic [31:0] field;
    logic [2:0]  wtype;
  } pbwp_state_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [31:0] field;
    logic [2:0]  wtype;
    logic [63:0] value;
    logic        field_end;
    logic        message_end;
    error_e      err;
  } pbwp_result_t;

endpackage

FILE: rtl/core/pbwp_step.sv
// ----------------------------------------------------------------------------
// pbwp_step
// Decode of one message byte: next parser state and the result it causes.
// ----------------------------------------------------------------------------
module pbwp_step import pbwp_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  pbwp_state_t            state_i,
  input  logic [LENGTH_BITS-1:0] rem_i,
  input  logic [LENGTH_BITS-1:0] pay_i,
  input  logic [7:0]             byte_i,
  output pbwp_state_t            state_o,
  output logic [LENGTH_BITS-1:0] rem_o,
  output logic [LENGTH_BITS-1:0] pay_o,
  output pbwp_result_t           result_o
);

  logic                   active;
  logic                   last;
  logic [LENGTH_BITS-1:0] left;
  logic [LENGTH_BITS-1:0] pay_dec;
  logic [5:0]             shamt;
  logic [3:0]             shift_inc;
  logic [63:0]            acc_new;
  logic [31:0]            key_field;
  logic [2:0]             key_wtype;

  logic   res_valid;
  kind_e  res_kind;
  error_e res_err;

  assign active    = state_i.phase inside {PH_KEY, PH_VARINT, PH_LENGTH, PH_PAYLOAD};
  assign last      = (rem_i == LENGTH_BITS'(1));
  assign left      = rem_i - LENGTH_BITS'(1);
  assign pay_dec   = pay_i - LENGTH_BITS'(1);
  assign shamt     = 6'({2'b00, state_i.shift}) * 6'd7;
  assign shift_inc = state_i.shift + 4'd1;
  assign acc_new   = state_i.acc | (64'(byte_i[6:0]) << shamt);
  assign key_field = acc_new[34:3];
  assign key_wtype = acc_new[2:0];

  // next state
  always_comb begin
    state_o   = state_i;
    pay_o     = pay_i;
    rem_o     = rem_i;
    res_valid = 1'b0;
    res_kind  = KIND_ERROR;
    res_err   = ERR_NONE;
    if (active) begin
      rem_o = left;
      if (state_i.phase == PH_PAYLOAD) begin
        pay_o     = pay_dec;
        res_valid = 1'b1;
        res_kind  = KIND_PAYLOAD;
        if (pay_dec == '0) begin
          state_o.phase = last ? PH_DONE : PH_KEY;
        end
      end else if (byte_i[7]) begin
        state_o.acc   = acc_new;
        state_o.shift = shift_inc;
        if (shift_inc >= 4'(MAX_VARINT_BYTES)) begin
          state_o.phase = PH_ERROR;
          res_valid     = 1'b1;
          res_err       = ERR_LONG_VARINT;
        end else if (last) begin
          state_o.phase = PH_ERROR;
          res_valid     = 1'b1;
          res_err       = ERR_TRUNC_VARINT;
        end
      end else begin
        state_o.acc   = '0;
        state_o.shift = '0;
        case (state_i.phase)
          PH_KEY: begin
            state_o.field = key_field;
            state_o.wtype = key_wtype;
            if (key_field == '0) begin
              res_err = ERR_FIELD_ZERO;
            end else begin
              case (key_wtype)
                WT_VARINT: begin
                  if (last) res_err = ERR_TRUNC_VARINT;
                  else state_o.phase = PH_VARINT;
                end
                WT_BYTES: begin
                  if (last) res_err = ERR_TRUNC_VARINT;
                  else state_o.phase = PH_LENGTH;
                end
                WT_FIXED64: begin
                  if (left < LENGTH_BITS'(FIXED64_BYTES)) begin
                    res_err = ERR_TRUNC_FIXED64;
                  end else begin
                    pay_o         = LENGTH_BITS'(FIXED64_BYTES);
                    state_o.phase = PH_PAYLOAD;
                  end
                end
                WT_FIXED32: begin
                  if (left < LENGTH_BITS'(FIXED32_BYTES)) begin
                    res_err = ERR_TRUNC_FIXED32;
                  end else begin
                    pay_o         = LENGTH_BITS'(FIXED32_BYTES);
                    state_o.phase = PH_PAYLOAD;
                  end
                end
                default: res_err = ERR_BAD_WIRE_TYPE;
              endcase
            end
            if (res_err != ERR_NONE) begin
              state_o.phase = PH_ERROR;
              res_valid     = 1'b1;
            end
          end
          PH_VARINT: begin
            state_o.phase = last ? PH_DONE : PH_KEY;
            res_valid     = 1'b1;
            res_kind      = KIND_VARINT;
          end
          PH_LENGTH: begin
            if (acc_new > 64'(left)) begin
              state_o.phase = PH_ERROR;
              res_valid     = 1'b1;
              res_err       = ERR_TRUNC_BYTES;
            end else if (acc_new == '0) begin
              state_o.phase = last ? PH_DONE : PH_KEY;
              res_valid     = 1'b1;
              res_kind      = KIND_EMPTY;
            end else begin
              pay_o         = acc_new[LENGTH_BITS-1:0];
              state_o.phase = PH_PAYLOAD;
            end
          end
          default: begin
            state_o.phase = PH_ERROR;
          end
        endcase
      end
    end
  end

  // result
  always_comb begin
    result_o.valid       = res_valid;
    result_o.kind        = res_kind;
    result_o.field       = state_o.field;
    result_o.wtype       = state_o.wtype;
    result_o.err         = res_err;
    result_o.value       = '0;
    result_o.field_end   = 1'b1;
    result_o.message_end = 1'b1;
    case (res_kind)
      KIND_VARINT: begin
        result_o.value       = acc_new;
        result_o.message_end = last;
      end
      KIND_PAYLOAD: begin
        result_o.value       = 64'(byte_i);
        result_o.field_end   = (pay_dec == '0);
        result_o.message_end = last;
      end
      KIND_EMPTY: begin
        result_o.message_end = last;
      end
      default: begin
        result_o.value = '0;
      end
    endcase
  end

endmodule

FILE: rtl/core/protobuf_wire_parser_top.sv
// ----------------------------------------------------------------------------
// protobuf_wire_parser_top
// Protocol Buffers wire-format decoder taking one message byte per beat.
// ----------------------------------------------------------------------------
// Writing the message length on the configuration channel restarts the parse;
// a length of zero finishes at once. Bytes are then taken one per cycle: each
// byte is decoded in the same cycle it is accepted (varint accumulate, key,
// length and payload count all resolve in one step) and any result it causes
// is loaded into a single output register. A byte is refused only while that
// register holds a result that the sink is stalling, so the sustained rate is
// one byte per cycle unless the sink stalls. Varint bytes that do not end a
// value, and key bytes, give no result unless they raise an error; after the
// first error all bytes are consumed silently until the next length write.
module protobuf_wire_parser_top import pbwp_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] field_id_o,
  output logic [2:0]  wtype_o,
  output logic [63:0] value_o,
  output logic        field_end_o,
  output logic        message_end_o,
  output logic [2:0]  error_code_o
);

  pbwp_state_t            state_q, state_d, step_state;
  logic [LENGTH_BITS-1:0] rem_q, rem_d, step_rem;
  logic [LENGTH_BITS-1:0] pay_q, pay_d, step_pay;
  logic [LENGTH_BITS-1:0] cfg_len;
  pbwp_result_t           step_res;
  pbwp_result_t           out_q;
  logic                   out_valid_q;
  logic                   in_acc;
  logic                   cfg_acc;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_len     = LENGTH_BITS'(cfg_data_i);

  pbwp_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .state_i  (state_q),
    .rem_i    (rem_q),
    .pay_i    (pay_q),
    .byte_i   (in_byte_i),
    .state_o  (step_state),
    .rem_o    (step_rem),
    .pay_o    (step_pay),
    .result_o (step_res)
  );

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    pay_d   = pay_q;
    if (cfg_acc) begin
      state_d       = '0;
      state_d.phase = (cfg_len == '0) ? PH_DONE : PH_KEY;
      rem_d         = cfg_len;
      pay_d         = '0;
    end else if (in_acc) begin
      state_d = step_state;
      rem_d   = step_rem;
      pay_d   = step_pay;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      rem_q   <= '0;
      pay_q   <= '0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      pay_q   <= pay_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && step_res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && step_res.valid) begin
      out_q <= step_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_q.kind;
  assign field_id_o    = out_q.field;
  assign wtype_o       = out_q.wtype;
  assign value_o       = out_q.value;
  assign field_end_o   = out_q.field_end;
  assign message_end_o = out_q.message_end;
  assign error_code_o  = out_q.err;

  a_error_stops_parse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !cfg_acc && step_res.valid && step_res.kind == KIND_ERROR
    |=> state_q.phase == PH_ERROR)
    else $error("error beat did not stop the parse");

  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_ERROR
    |-> out_q.err != ERR_NONE && out_q.message_end && out_q.field_end)
    else $error("error beat without code or end marks");

  a_no_error_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind != KIND_ERROR |-> out_q.err == ERR_NONE)
    else $error("error code on a data beat");

  a_quiet_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_IDLE || state_q.phase == PH_DONE ||
     state_q.phase == PH_ERROR) |-> !step_res.valid)
    else $error("result while parser is stopped");

  a_bytes_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_KEY || state_q.phase == PH_VARINT ||
     state_q.phase == PH_LENGTH || state_q.phase == PH_PAYLOAD)
    |-> rem_q != '0 && state_q.shift < 4'(MAX_VARINT_BYTES))
    else $error("parser active past the message end");

endmodule
